### design/assert_macros.svh
// Assertion helpers used by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated: next-cycle implication");

`endif

### design/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  localparam logic [7:0] SYNC_FIRST  = 8'h06;
  localparam logic [7:0] SYNC_SECOND = 8'h85;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_GOOD   = 2'd1,
    KIND_BADSUM = 2'd2,
    KIND_DROP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_OWN_ID         = 3'd0,
    REG_ACCEPT_ALL     = 3'd1,
    REG_ALLOWED        = 3'd2,
    REG_STRUCT_SIZES   = 3'd3,
    REG_STRUCT_PRESENT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  own_id;
    logic        accept_all;
    logic [63:0] allowed_senders;
    logic [63:0] struct_sizes;
    logic [7:0]  struct_present;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [2:0] slot;
    logic [7:0] sender;
  } res_t;

endpackage

### design/sfr_cfg_regs.sv
module sfr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
  output logic [sfr_pkg::DATA_W-1:0]  prdata,
  output sfr_pkg::cfg_t               cfg
);

  sfr_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[sfr_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id          <= 8'd0;
      cfg_r.accept_all      <= 1'b1;
      cfg_r.allowed_senders <= 64'd0;
      cfg_r.struct_sizes    <= 64'd0;
      cfg_r.struct_present  <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        sfr_pkg::REG_OWN_ID:         cfg_r.own_id          <= pwdata[7:0];
        sfr_pkg::REG_ACCEPT_ALL:     cfg_r.accept_all      <= pwdata[0];
        sfr_pkg::REG_ALLOWED:        cfg_r.allowed_senders <= pwdata;
        sfr_pkg::REG_STRUCT_SIZES:   cfg_r.struct_sizes    <= pwdata;
        sfr_pkg::REG_STRUCT_PRESENT: cfg_r.struct_present  <= pwdata[7:0];
        default: begin
          // drop writes outside the register map
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfr_pkg::REG_OWN_ID:         prdata = {56'd0, cfg_r.own_id};
      sfr_pkg::REG_ACCEPT_ALL:     prdata = {63'd0, cfg_r.accept_all};
      sfr_pkg::REG_ALLOWED:        prdata = cfg_r.allowed_senders;
      sfr_pkg::REG_STRUCT_SIZES:   prdata = cfg_r.struct_sizes;
      sfr_pkg::REG_STRUCT_PRESENT: prdata = {56'd0, cfg_r.struct_present};
      default:                     prdata = '0;
    endcase
  end

endmodule

### design/struct_frame_receiver.sv
// Frame receiver: takes one received byte per clock while in_stall is low and
// parses frames of the form 0x06 0x85, destination, sender, struct slot, length,
// payload bytes, XOR checksum. A result (payload byte, frame good, checksum error
// or frame dropped) is registered when the byte that causes it is accepted: into
// the output register, or into the skid register while the output register holds
// a result that is not taken. These form a two-entry output buffer, so bytes
// keep flowing while a result waits; in_stall rises only when both entries hold
// results that have not been taken. Registers sit on a 64-bit APB port at byte
// addresses 8*i: own_id, accept_all, allowed_senders, struct_sizes, struct_present.
// Configure only while no frame is in progress.
`include "assert_macros.svh"

module struct_frame_receiver #(
  parameter int unsigned STRUCT_SLOTS    = 8,
  parameter int unsigned ALLOWED_ENTRIES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_data,
  output logic [7:0]                  out_index,
  output logic [2:0]                  out_slot,
  output logic [7:0]                  out_sender,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
  output logic [sfr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_DEST    = 3'd2,
    PH_SENDER  = 3'd3,
    PH_SLOT    = 3'd4,
    PH_LEN     = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_CSUM    = 3'd7
  } phase_t;

  sfr_pkg::cfg_t cfg;

  phase_t        phase_r,   phase_nxt;
  logic [7:0]    sender_r,  sender_nxt;
  logic [2:0]    slot_r,    slot_nxt;
  logic [7:0]    exp_len_r, exp_len_nxt;
  logic [7:0]    pos_r,     pos_nxt;
  logic [7:0]    xor_r,     xor_nxt;

  sfr_pkg::res_t out_r, skid_r, res;
  logic          out_v_r, skid_v_r;
  logic          res_v;
  logic          in_acc, push, pop;
  logic          sender_ok;
  logic [7:0]    b;
  logic [7:0]    size_sel;
  logic [7:0]    pos_inc;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready   = 1'b1;
  assign b        = in_rx_byte;
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign push     = in_acc && res_v;
  assign pop      = out_v_r && !out_stall;
  assign size_sel = cfg.struct_sizes[8*slot_r +: 8];
  assign pos_inc  = pos_r + 8'd1;

  always_comb begin
    sender_ok = 1'b0;
    for (int k = 0; k < ALLOWED_ENTRIES; k++) begin
      if (cfg.allowed_senders[8*k +: 8] == b) sender_ok = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    sender_nxt  = sender_r;
    slot_nxt    = slot_r;
    exp_len_nxt = exp_len_r;
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    res_v       = 1'b0;
    res.kind    = sfr_pkg::KIND_DROP;
    res.data    = 8'd0;
    res.index   = 8'd0;
    case (phase_r)
      PH_HUNT: begin
        if (b == sfr_pkg::SYNC_FIRST) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_nxt  = (b == sfr_pkg::SYNC_SECOND) ? PH_DEST : PH_HUNT;
        sender_nxt = 8'd0;
        slot_nxt   = 3'd0;
      end
      PH_DEST: begin
        if (b != 8'd0 && b != cfg.own_id) begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
        end else begin
          phase_nxt = PH_SENDER;
        end
      end
      PH_SENDER: begin
        sender_nxt = b;
        if (!cfg.accept_all && !sender_ok) begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
        end else begin
          phase_nxt = PH_SLOT;
        end
      end
      PH_SLOT: begin
        if (b >= 8'(STRUCT_SLOTS) || !cfg.struct_present[b[2:0]]) begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
        end else begin
          slot_nxt  = b[2:0];
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (size_sel != b) begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
        end else begin
          exp_len_nxt = b;
          pos_nxt     = 8'd0;
          xor_nxt     = b;
          // an empty frame has no checksum byte
          phase_nxt   = (b == 8'd0) ? PH_HUNT : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xor_nxt   = xor_r ^ b;
        pos_nxt   = pos_inc;
        if (pos_inc >= exp_len_r) phase_nxt = PH_CSUM;
        res_v     = 1'b1;
        res.kind  = sfr_pkg::KIND_DATA;
        res.data  = b;
        res.index = pos_r;
      end
      PH_CSUM: begin
        phase_nxt = PH_HUNT;
        res_v     = 1'b1;
        res.kind  = (b == xor_r) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BADSUM;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    res.slot   = slot_nxt;
    res.sender = sender_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      sender_r  <= 8'd0;
      slot_r    <= 3'd0;
      exp_len_r <= 8'd0;
      pos_r     <= 8'd0;
      xor_r     <= 8'd0;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r   <= phase_nxt;
        sender_r  <= sender_nxt;
        slot_r    <= slot_nxt;
        exp_len_r <= exp_len_nxt;
        pos_r     <= pos_nxt;
        xor_r     <= xor_nxt;
      end
      if (pop) begin
        // a full skid blocks input, so no push can coincide with a skid refill
        if (skid_v_r) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= push;
          out_r   <= res;
        end
      end else if (push) begin
        if (out_v_r) begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end else begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_kind   = out_r.kind;
  assign out_data   = out_r.data;
  assign out_index  = out_r.index;
  assign out_slot   = out_r.slot;
  assign out_sender = out_r.sender;

  `ASSERT_IMPLIES(a_skid_behind_out, skid_v_r, out_v_r)
  `ASSERT_IMPLIES(a_quiet_header, in_acc && (phase_r == PH_HUNT || phase_r == PH_SYNC2), !push)
  `ASSERT_NEXT(a_csum_ends_frame, in_acc && phase_r == PH_CSUM, phase_r == PH_HUNT)
  `ASSERT_IMPLIES(a_pos_in_range, phase_r == PH_PAYLOAD, pos_r < exp_len_r)

endmodule

### test/struct_frame_receiver_tb.sv
module struct_frame_receiver_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef enum logic [2:0] {
    ST_HUNT, ST_SYNC2, ST_DEST, ST_SENDER, ST_SLOT, ST_LEN, ST_PAYLOAD, ST_CSUM
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic [7:0] out_index;
  logic [2:0] out_slot;
  logic [7:0] out_sender;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sfr_pkg::ADDR_W-1:0] paddr = '0;
  logic [sfr_pkg::DATA_W-1:0] pwdata = '0;
  logic [sfr_pkg::DATA_W-1:0] prdata;
  logic pready;

  // register mirror
  logic [7:0] cfg_own_id = 8'h00;
  logic cfg_accept_all = 1'b1;
  logic [63:0] cfg_allowed = '0;
  logic [63:0] cfg_sizes = '0;
  logic [7:0] cfg_present = '0;

  // parser mirror
  parse_phase_t phase = ST_HUNT;
  logic [7:0] cur_sender = '0;
  logic [2:0] cur_slot = '0;
  logic [7:0] want_len = '0;
  logic [7:0] pos = '0;
  logic [7:0] run_xor = '0;

  logic [7:0] tx_bytes[$];
  sfr_pkg::res_t expected_results[$];
  sfr_pkg::res_t want;

  bit in_fire = 0;
  bit idle_on = 1;
  int send_gap = 0;
  int stall_gap = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int errors = 0;
  int cycles = 0;

  struct_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_data(out_data), .out_index(out_index),
    .out_slot(out_slot), .out_sender(out_sender),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic bit sender_listed(input logic [7:0] who);
    for (int k = 0; k < 8; k++) begin
      if (cfg_allowed[8*k +: 8] == who) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parser mirror by one byte; queue the result it causes, if any.
  task automatic parse_byte(input logic [7:0] b);
    sfr_pkg::res_t r;
    bit emit;
    emit = 1'b0;
    r = '0;
    r.kind = sfr_pkg::KIND_DROP;
    case (phase)
      ST_HUNT: begin
        if (b == sfr_pkg::SYNC_FIRST) phase = ST_SYNC2;
      end
      ST_SYNC2: begin
        phase = (b == sfr_pkg::SYNC_SECOND) ? ST_DEST : ST_HUNT;
        cur_sender = '0;
        cur_slot = '0;
      end
      ST_DEST: begin
        if (b != 8'h00 && b != cfg_own_id) emit = 1'b1;
        else phase = ST_SENDER;
      end
      ST_SENDER: begin
        cur_sender = b;
        if (!cfg_accept_all && !sender_listed(b)) emit = 1'b1;
        else phase = ST_SLOT;
      end
      ST_SLOT: begin
        if (b >= 8 || !cfg_present[b[2:0]]) begin
          emit = 1'b1;
        end else begin
          cur_slot = b[2:0];
          phase = ST_LEN;
        end
      end
      ST_LEN: begin
        if (cfg_sizes[8*cur_slot +: 8] != b) begin
          emit = 1'b1;
        end else begin
          want_len = b;
          pos = '0;
          run_xor = b;
          phase = (b == 8'h00) ? ST_HUNT : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        emit = 1'b1;
        r.kind = sfr_pkg::KIND_DATA;
        r.data = b;
        r.index = pos;
        run_xor = run_xor ^ b;
        pos = pos + 8'd1;
        if (pos >= want_len) phase = ST_CSUM;
      end
      default: begin
        emit = 1'b1;
        r.kind = (b == run_xor) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BADSUM;
        phase = ST_HUNT;
      end
    endcase
    // drops fall back to hunting
    if (emit && r.kind == sfr_pkg::KIND_DROP) phase = ST_HUNT;
    if (emit) begin
      r.slot = cur_slot;
      r.sender = cur_sender;
      expected_results.push_back(r);
    end
  endtask

  // Queue one frame, mostly well formed, sometimes broken; return its byte count.
  function automatic int queue_random_frame();
    logic [7:0] fr[$];
    logic [7:0] dest, snd, sl, size, len, cs, x;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 10) begin
      fr.push_back(sfr_pkg::SYNC_FIRST);
      x = 8'($urandom_range(0, 255));
      if (x == sfr_pkg::SYNC_SECOND) x = 8'h00;
      fr.push_back(x);
    end else begin
      fr.push_back(sfr_pkg::SYNC_FIRST);
      fr.push_back(sfr_pkg::SYNC_SECOND);
      if ($urandom_range(0, 99) < 85) dest = $urandom_range(0, 1) ? cfg_own_id : 8'h00;
      else dest = 8'($urandom_range(0, 255));
      fr.push_back(dest);
      if ($urandom_range(0, 99) < 85) snd = cfg_allowed[8*$urandom_range(0, 7) +: 8];
      else snd = 8'($urandom_range(0, 255));
      fr.push_back(snd);
      if ($urandom_range(0, 99) < 85) begin
        sl = 8'($urandom_range(0, 7));
        for (int k = 0; k < 8 && !cfg_present[sl[2:0]]; k++) sl = 8'($urandom_range(0, 7));
      end else begin
        case ($urandom_range(0, 2))
          0: sl = 8'($urandom_range(8, 255));
          1: sl = 8'($urandom_range(0, 7));
          default: sl = 8'hFF;
        endcase
      end
      fr.push_back(sl);
      size = (sl < 8) ? cfg_sizes[8*sl[2:0] +: 8] : 8'($urandom_range(0, 255));
      len = ($urandom_range(0, 99) < 90) ? size : 8'($urandom_range(0, 255));
      fr.push_back(len);
      if (sl < 8 && len == size && len != 8'h00) begin
        cs = len;
        repeat (len) begin
          x = 8'($urandom_range(0, 255));
          cs = cs ^ x;
          fr.push_back(x);
        end
        if ($urandom_range(0, 99) < 85) fr.push_back(cs);
        else fr.push_back(cs ^ 8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 24) == 0) fr = fr[0:fr.size()-1-$urandom_range(1, 2)];
    end
    foreach (fr[i]) tx_bytes.push_back(fr[i]);
    return fr.size();
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      sfr_pkg::REG_OWN_ID: cfg_own_id = val[7:0];
      sfr_pkg::REG_ACCEPT_ALL: cfg_accept_all = val[0];
      sfr_pkg::REG_ALLOWED: cfg_allowed = val;
      sfr_pkg::REG_STRUCT_SIZES: cfg_sizes = val;
      sfr_pkg::REG_STRUCT_PRESENT: cfg_present = val[7:0];
      default: ;
    endcase
  endtask

  // Hold until every byte is taken and every result has come, then let the
  // pipeline settle for bytes that cause nothing.
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_bytes(input logic [7:0] bs[]);
    foreach (bs[i]) tx_bytes.push_back(bs[i]);
  endfunction

  function automatic void queue_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) sent += queue_random_frame();
  endfunction

  function automatic logic [63:0] random_sizes(input int lo, input int hi);
    logic [63:0] v;
    for (int k = 0; k < 8; k++) v[8*k +: 8] = 8'($urandom_range(lo, hi));
    return v;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() > 0) begin
        if (idle_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check the result transaction, then predict from the byte taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: kind %0d data %0h", out_kind, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            errors++;
          end
          if (out_data != want.data) begin
            $error("data: expected %0h, got %0h", want.data, out_data);
            errors++;
          end
          if (out_index != want.index) begin
            $error("index: expected %0d, got %0d", want.index, out_index);
            errors++;
          end
          if (out_slot != want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot);
            errors++;
          end
          if (out_sender != want.sender) begin
            $error("sender: expected %0h, got %0h", want.sender, out_sender);
            errors++;
          end
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) parse_byte(in_rx_byte);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("struct_frame_receiver verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] sizes_v;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: no slot registered, so every header that passes the destination check drops at the slot
    queue_bytes({8'h00, 8'hFF, sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_FIRST,
                 sfr_pkg::SYNC_SECOND, sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND,
                 8'h00, 8'h00, 8'h00});
    queue_random(80);
    wait_idle();

    // extra bits above each register are ignored; accept_all 2 reads as 0
    cfg_write(sfr_pkg::REG_OWN_ID, 64'hFFFF_FFFF_FFFF_FF5A);
    cfg_write(sfr_pkg::REG_ACCEPT_ALL, 64'h2);
    cfg_write(sfr_pkg::REG_ALLOWED, 64'h00FF_1122_3344_5566);
    cfg_write(sfr_pkg::REG_STRUCT_SIZES, 64'h0604_0502_0803_0100);
    cfg_write(sfr_pkg::REG_STRUCT_PRESENT, 64'hFF00_007F);
    cfg_write(REG_SPARE, 64'hDEAD_BEEF_0000_00FF);
    queue_bytes({sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, 8'h5A, 8'hFF, 8'h01,
                 8'h01, 8'hC3, 8'hC2,
                 sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00,
                 sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, 8'h33,
                 sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, 8'h00, 8'h77,
                 sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, 8'h00, 8'h11, 8'h08});
    wait_idle();
    // long receiver hold while bytes keep coming
    holds_asked++;
    queue_random(250);
    wait_idle();
    queue_random(250);
    wait_idle();

    // extremes: everyone allowed, every slot present, one full-size slot
    sizes_v = random_sizes(1, 12);
    sizes_v[63:56] = 8'hFF;
    cfg_write(sfr_pkg::REG_OWN_ID, 64'hFF);
    cfg_write(sfr_pkg::REG_ACCEPT_ALL, 64'h1);
    cfg_write(sfr_pkg::REG_ALLOWED, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(sfr_pkg::REG_STRUCT_SIZES, sizes_v);
    cfg_write(sfr_pkg::REG_STRUCT_PRESENT, 64'hFF);
    queue_random(500);
    wait_idle();

    cfg_write(sfr_pkg::REG_OWN_ID, 64'h00);
    cfg_write(sfr_pkg::REG_ACCEPT_ALL, 64'h0);
    cfg_write(sfr_pkg::REG_ALLOWED, 64'h0);
    cfg_write(sfr_pkg::REG_STRUCT_SIZES, random_sizes(0, 6));
    cfg_write(sfr_pkg::REG_STRUCT_PRESENT, 64'($urandom_range(0, 255)));
    holds_asked++;
    queue_random(300);
    wait_idle();

    // final stretch without idling on either side
    idle_on = 0;
    cfg_write(sfr_pkg::REG_OWN_ID, 64'($urandom_range(1, 254)));
    cfg_write(sfr_pkg::REG_ACCEPT_ALL, 64'($urandom_range(0, 1)));
    cfg_write(sfr_pkg::REG_ALLOWED, {$urandom, $urandom});
    cfg_write(sfr_pkg::REG_STRUCT_SIZES, random_sizes(1, 10));
    cfg_write(sfr_pkg::REG_STRUCT_PRESENT, 64'($urandom_range(0, 255) | 1));
    queue_random(400);
    wait_idle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("struct_frame_receiver verification clean");
    end else begin
      $display("struct_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
